FILE: rtl/spbl_pkg.sv
// Package for the slot pool with bucket lists: field widths, codes, and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package spbl_pkg;

  localparam int unsigned SlotW        = 10;
  localparam int unsigned TileW        = 6;
  localparam int unsigned ActW         = 3;
  localparam int unsigned StatW        = 2;
  localparam int unsigned NumSlotsDef  = 1024;
  localparam int unsigned GridSideDef  = 64;

  typedef enum logic [ActW-1:0] {
    ACT_FIND      = 3'd0,
    ACT_OCCUPY    = 3'd1,
    ACT_FREE      = 3'd2,
    ACT_APPEND    = 3'd3,
    ACT_REMOVE    = 3'd4,
    ACT_READ_HEAD = 3'd5,
    ACT_READ_LINK = 3'd6
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // Memory read selection; the pointer registers follow the read
  typedef enum logic [2:0] {
    RD_NONE,
    RD_SLOT,        // slot entry of the request slot
    RD_SCAN_FIRST,  // slot 1, scan restarts
    RD_SCAN_NEXT,   // scan + 1
    RD_HEAD_NEXT,   // slot entry at the tile head, walk restarts
    RD_WALK_NEXT,   // slot entry at the current link, walk advances
    RD_TILE         // tile head of the request tile
  } rd_sel_e;

  typedef enum logic [2:0] {
    SW_NONE,
    SW_CLEAR,
    SW_IDLE_ENTRY,     // slot: used, off tile, no link
    SW_FREE,           // slot: unused, keep link
    SW_ON_END,         // slot: used, on tile, no link
    SW_CUR_LINK_S,     // walk slot links to request slot
    SW_CUR_LINK_SNEXT  // walk slot links past request slot
  } swr_sel_e;

  typedef enum logic [1:0] {
    TW_NONE,
    TW_CLEAR,
    TW_SLOT,
    TW_SNEXT
  } twr_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_SCAN,
    RES_NEXT,
    RES_HEAD
  } res_sel_e;

  typedef struct packed {
    logic      req_load;
    rd_sel_e   rd_sel;
    swr_sel_e  swr_sel;
    twr_sel_e  twr_sel;
    logic      snext_load;
    logic      res_load;
    res_sel_e  res_sel;
    status_e   res_status;
    logic      out_load;
    logic      clr_step;
  } dp_cmd_t;

  typedef struct packed {
    action_e act;
    logic    slot_ok;
    logic    tile_ok;
    logic    sd_used;
    logic    sd_on;
    logic    nxt_zero;
    logic    nxt_is_s;
    logic    hd_zero;
    logic    hd_is_s;
    logic    scan_last;
    logic    app_more;
    logic    rem_more;
    logic    clr_done;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/spbl_dp.sv
// Datapath: slot and tile memories, request, pointer and result registers.
// Depends on spbl_pkg; driven by spbl_ctrl through dp_cmd_t.
`default_nettype none
module spbl_dp #(
  parameter int unsigned NUM_SLOTS = spbl_pkg::NumSlotsDef,
  parameter int unsigned GRID_SIDE = spbl_pkg::GridSideDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire spbl_pkg::dp_cmd_t          cmd_i,
  output spbl_pkg::dp_status_t            sts_o,
  input  wire logic [spbl_pkg::ActW-1:0]  action_i,
  input  wire logic [spbl_pkg::SlotW-1:0] slot_i,
  input  wire logic [spbl_pkg::TileW-1:0] tile_x_i,
  input  wire logic [spbl_pkg::TileW-1:0] tile_y_i,
  output logic      [spbl_pkg::SlotW-1:0] slot_out_o,
  output logic      [spbl_pkg::StatW-1:0] status_o
);

  localparam int unsigned NumTiles = GRID_SIDE * GRID_SIDE;
  localparam int unsigned SlotIdxW = $clog2(NUM_SLOTS);
  localparam int unsigned TileIdxW = $clog2(NumTiles);
  localparam int unsigned EntW     = SlotIdxW + 2;
  localparam int unsigned ClrDepth = (NUM_SLOTS > NumTiles) ? NUM_SLOTS : NumTiles;
  localparam int unsigned ClrW     = $clog2(ClrDepth);

  // entry: {used, on_tile, next}
  logic [EntW-1:0]     slot_mem [NUM_SLOTS];
  logic [SlotIdxW-1:0] tile_mem [NumTiles];

  logic [spbl_pkg::ActW-1:0] act_q;
  logic                      slot_ok_q, tile_ok_q;
  logic [SlotIdxW-1:0]       s_q, scan_q, cur_q, snext_q, hd_q, res_q;
  logic [TileIdxW-1:0]       t_q;
  logic [SlotIdxW:0]         steps_q;
  logic [EntW-1:0]           sd_q;
  spbl_pkg::status_e         stat_q;
  logic [spbl_pkg::SlotW-1:0] out_slot_q;
  logic [spbl_pkg::StatW-1:0] out_stat_q;
  logic [ClrW-1:0]           clr_q;

  logic                sd_used, sd_on;
  logic [SlotIdxW-1:0] sd_next;
  assign sd_used = sd_q[EntW-1];
  assign sd_on   = sd_q[EntW-2];
  assign sd_next = sd_q[SlotIdxW-1:0];

  logic [31:0] slot32, tile32, res32;
  assign slot32 = 32'(slot_i);
  assign tile32 = 32'(tile_y_i) * GRID_SIDE + 32'(tile_x_i);
  assign res32  = 32'(res_q);

  // Write and read port selection
  logic                swr_en, twr_en, srd_en, trd_en;
  logic [SlotIdxW-1:0] swr_addr, srd_addr;
  logic [EntW-1:0]     swr_data;
  logic [TileIdxW-1:0] twr_addr;
  logic [SlotIdxW-1:0] twr_data;

  always_comb begin
    swr_en   = 1'b0;
    swr_addr = s_q;
    swr_data = '0;
    unique case (cmd_i.swr_sel)
      spbl_pkg::SW_NONE: ;
      spbl_pkg::SW_CLEAR: begin
        swr_en   = 32'(clr_q) < NUM_SLOTS;
        swr_addr = clr_q[SlotIdxW-1:0];
      end
      spbl_pkg::SW_IDLE_ENTRY: begin
        swr_en   = 1'b1;
        swr_data = {1'b1, 1'b0, {SlotIdxW{1'b0}}};
      end
      spbl_pkg::SW_FREE: begin
        swr_en   = 1'b1;
        swr_data = {1'b0, 1'b0, sd_next};
      end
      spbl_pkg::SW_ON_END: begin
        swr_en   = 1'b1;
        swr_data = {1'b1, 1'b1, {SlotIdxW{1'b0}}};
      end
      spbl_pkg::SW_CUR_LINK_S: begin
        swr_en   = 1'b1;
        swr_addr = cur_q;
        swr_data = {sd_used, sd_on, s_q};
      end
      spbl_pkg::SW_CUR_LINK_SNEXT: begin
        swr_en   = 1'b1;
        swr_addr = cur_q;
        swr_data = {sd_used, sd_on, snext_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    twr_en   = 1'b0;
    twr_addr = t_q;
    twr_data = '0;
    unique case (cmd_i.twr_sel)
      spbl_pkg::TW_NONE: ;
      spbl_pkg::TW_CLEAR: begin
        twr_en   = 32'(clr_q) < NumTiles;
        twr_addr = clr_q[TileIdxW-1:0];
      end
      spbl_pkg::TW_SLOT: begin
        twr_en   = 1'b1;
        twr_data = s_q;
      end
      spbl_pkg::TW_SNEXT: begin
        twr_en   = 1'b1;
        twr_data = snext_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    srd_en   = 1'b1;
    trd_en   = 1'b0;
    srd_addr = s_q;
    unique case (cmd_i.rd_sel)
      spbl_pkg::RD_NONE:       srd_en = 1'b0;
      spbl_pkg::RD_SLOT:       srd_addr = s_q;
      spbl_pkg::RD_SCAN_FIRST: srd_addr = SlotIdxW'(1);
      spbl_pkg::RD_SCAN_NEXT:  srd_addr = scan_q + 1'b1;
      spbl_pkg::RD_HEAD_NEXT:  srd_addr = hd_q;
      spbl_pkg::RD_WALK_NEXT:  srd_addr = sd_next;
      spbl_pkg::RD_TILE: begin
        srd_en = 1'b0;
        trd_en = 1'b1;
      end
      default:                 srd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (swr_en) slot_mem[swr_addr] <= swr_data;
    if (srd_en) sd_q <= slot_mem[srd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (twr_en) tile_mem[twr_addr] <= twr_data;
    if (trd_en) hd_q <= tile_mem[t_q];
  end

  // Clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step && !sts_o.clr_done) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Request, pointer and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      act_q     <= action_i;
      slot_ok_q <= (slot32 != 32'd0) && (slot32 < NUM_SLOTS);
      tile_ok_q <= (32'(tile_x_i) < GRID_SIDE) && (32'(tile_y_i) < GRID_SIDE);
      s_q       <= slot32[SlotIdxW-1:0];
      t_q       <= tile32[TileIdxW-1:0];
    end
    unique case (cmd_i.rd_sel)
      spbl_pkg::RD_SCAN_FIRST: scan_q <= SlotIdxW'(1);
      spbl_pkg::RD_SCAN_NEXT:  scan_q <= scan_q + 1'b1;
      spbl_pkg::RD_HEAD_NEXT: begin
        cur_q   <= hd_q;
        steps_q <= '0;
      end
      spbl_pkg::RD_WALK_NEXT: begin
        cur_q   <= sd_next;
        steps_q <= steps_q + 1'b1;
      end
      default: ;
    endcase
    if (cmd_i.snext_load) snext_q <= sd_next;
    if (cmd_i.res_load) begin
      stat_q <= cmd_i.res_status;
      unique case (cmd_i.res_sel)
        spbl_pkg::RES_ZERO: res_q <= '0;
        spbl_pkg::RES_SCAN: res_q <= scan_q;
        spbl_pkg::RES_NEXT: res_q <= sd_next;
        spbl_pkg::RES_HEAD: res_q <= hd_q;
        default:            res_q <= '0;
      endcase
    end
    if (cmd_i.out_load) begin
      out_slot_q <= res32[spbl_pkg::SlotW-1:0];
      out_stat_q <= stat_q;
    end
  end

  assign sts_o.act       = spbl_pkg::action_e'(act_q);
  assign sts_o.slot_ok   = slot_ok_q;
  assign sts_o.tile_ok   = tile_ok_q;
  assign sts_o.sd_used   = sd_used;
  assign sts_o.sd_on     = sd_on;
  assign sts_o.nxt_zero  = (sd_next == '0);
  assign sts_o.nxt_is_s  = (sd_next == s_q);
  assign sts_o.hd_zero   = (hd_q == '0);
  assign sts_o.hd_is_s   = (hd_q == s_q);
  assign sts_o.scan_last = (32'(scan_q) == NUM_SLOTS - 1);
  assign sts_o.app_more  = 32'(steps_q) < NUM_SLOTS;
  assign sts_o.rem_more  = (32'(steps_q) + 32'd1) < NUM_SLOTS;
  assign sts_o.clr_done  = (32'(clr_q) == ClrDepth - 1);

  assign slot_out_o = out_slot_q;
  assign status_o   = out_stat_q;

endmodule
`default_nettype wire

FILE: rtl/spbl_ctrl.sv
// Controller: sequences each action over the datapath memories, one read a
// cycle, and owns the handshakes. Depends on spbl_pkg.
`default_nettype none
module spbl_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire spbl_pkg::dp_status_t sts_i,
  output spbl_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_FIND_CHK,
    S_SLOT_CHK,
    S_HEAD_CHK,
    S_APP_HEAD,
    S_APP_WALK,
    S_APP_FIN,
    S_REM_HEAD,
    S_REM_WALK,
    S_REM_FIN,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.swr_sel  = spbl_pkg::SW_CLEAR;
        cmd_o.twr_sel  = spbl_pkg::TW_CLEAR;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = spbl_pkg::ST_BAD;
        state_d          = S_RESP;
        unique case (sts_i.act)
          spbl_pkg::ACT_FIND: begin
            cmd_o.res_load = 1'b0;
            cmd_o.rd_sel   = spbl_pkg::RD_SCAN_FIRST;
            state_d        = S_FIND_CHK;
          end
          spbl_pkg::ACT_READ_HEAD: begin
            if (sts_i.tile_ok) begin
              cmd_o.res_load = 1'b0;
              cmd_o.rd_sel   = spbl_pkg::RD_TILE;
              state_d        = S_HEAD_CHK;
            end
          end
          spbl_pkg::ACT_OCCUPY, spbl_pkg::ACT_FREE, spbl_pkg::ACT_READ_LINK: begin
            if (sts_i.slot_ok) begin
              cmd_o.res_load = 1'b0;
              cmd_o.rd_sel   = spbl_pkg::RD_SLOT;
              state_d        = S_SLOT_CHK;
            end
          end
          spbl_pkg::ACT_APPEND, spbl_pkg::ACT_REMOVE: begin
            if (sts_i.slot_ok && sts_i.tile_ok) begin
              cmd_o.res_load = 1'b0;
              cmd_o.rd_sel   = spbl_pkg::RD_SLOT;
              state_d        = S_SLOT_CHK;
            end
          end
          default: ;
        endcase
      end
      S_FIND_CHK: begin
        if (!sts_i.sd_used) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = spbl_pkg::RES_SCAN;
          state_d        = S_RESP;
        end else if (sts_i.scan_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = spbl_pkg::ST_FULL;
          state_d          = S_RESP;
        end else begin
          cmd_o.rd_sel = spbl_pkg::RD_SCAN_NEXT;
        end
      end
      S_SLOT_CHK: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = spbl_pkg::ST_BAD;
        state_d          = S_RESP;
        unique case (sts_i.act)
          spbl_pkg::ACT_OCCUPY: begin
            if (!sts_i.sd_used) begin
              cmd_o.swr_sel    = spbl_pkg::SW_IDLE_ENTRY;
              cmd_o.res_status = spbl_pkg::ST_OK;
            end
          end
          spbl_pkg::ACT_FREE: begin
            if (sts_i.sd_used && !sts_i.sd_on) begin
              cmd_o.swr_sel    = spbl_pkg::SW_FREE;
              cmd_o.res_status = spbl_pkg::ST_OK;
            end
          end
          spbl_pkg::ACT_READ_LINK: begin
            cmd_o.res_sel    = spbl_pkg::RES_NEXT;
            cmd_o.res_status = spbl_pkg::ST_OK;
          end
          spbl_pkg::ACT_APPEND: begin
            if (sts_i.sd_used && !sts_i.sd_on) begin
              cmd_o.res_load = 1'b0;
              cmd_o.rd_sel   = spbl_pkg::RD_TILE;
              state_d        = S_APP_HEAD;
            end
          end
          spbl_pkg::ACT_REMOVE: begin
            if (sts_i.sd_used && sts_i.sd_on) begin
              cmd_o.res_load   = 1'b0;
              cmd_o.snext_load = 1'b1;
              cmd_o.rd_sel     = spbl_pkg::RD_TILE;
              state_d          = S_REM_HEAD;
            end
          end
          default: ;
        endcase
      end
      S_HEAD_CHK: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = spbl_pkg::RES_HEAD;
        state_d        = S_RESP;
      end
      S_APP_HEAD: begin
        if (sts_i.hd_zero) begin
          cmd_o.twr_sel  = spbl_pkg::TW_SLOT;
          cmd_o.swr_sel  = spbl_pkg::SW_ON_END;
          cmd_o.res_load = 1'b1;
          state_d        = S_RESP;
        end else begin
          cmd_o.rd_sel = spbl_pkg::RD_HEAD_NEXT;
          state_d      = S_APP_WALK;
        end
      end
      S_APP_WALK: begin
        if (!sts_i.nxt_zero && sts_i.app_more) begin
          cmd_o.rd_sel = spbl_pkg::RD_WALK_NEXT;
        end else begin
          cmd_o.swr_sel = spbl_pkg::SW_CUR_LINK_S;
          state_d       = S_APP_FIN;
        end
      end
      S_APP_FIN: begin
        cmd_o.swr_sel  = spbl_pkg::SW_ON_END;
        cmd_o.res_load = 1'b1;
        state_d        = S_RESP;
      end
      S_REM_HEAD: begin
        if (sts_i.hd_zero) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = spbl_pkg::ST_BAD;
          state_d          = S_RESP;
        end else if (sts_i.hd_is_s) begin
          cmd_o.twr_sel  = spbl_pkg::TW_SNEXT;
          cmd_o.swr_sel  = spbl_pkg::SW_IDLE_ENTRY;
          cmd_o.res_load = 1'b1;
          state_d        = S_RESP;
        end else begin
          cmd_o.rd_sel = spbl_pkg::RD_HEAD_NEXT;
          state_d      = S_REM_WALK;
        end
      end
      S_REM_WALK: begin
        if (sts_i.nxt_zero) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = spbl_pkg::ST_BAD;
          state_d          = S_RESP;
        end else if (sts_i.nxt_is_s) begin
          cmd_o.swr_sel = spbl_pkg::SW_CUR_LINK_SNEXT;
          state_d       = S_REM_FIN;
        end else if (sts_i.rem_more) begin
          cmd_o.rd_sel = spbl_pkg::RD_WALK_NEXT;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = spbl_pkg::ST_BAD;
          state_d          = S_RESP;
        end
      end
      S_REM_FIN: begin
        cmd_o.swr_sel  = spbl_pkg::SW_IDLE_ENTRY;
        cmd_o.res_load = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/slot_pool_with_bucket_lists.sv
// Top level of the slot pool with per-tile linked lists.
// Depends on spbl_pkg, spbl_ctrl and spbl_dp.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+--------------------------------------
//   in      | in_valid_i | in_stall_o  | action_i slot_i tile_x_i tile_y_i
//   out     | out_valid_o| out_stall_i | slot_out_o status_o
//
// After reset a clearing pass sweeps both memories, one counter running over
// max(NUM_SLOTS, GRID_SIDE*GRID_SIDE) addresses (4096 at the defaults); in_stall_o is high.
// find_free scans one slot entry a cycle, and append and remove walk a tile list
// one link a cycle, a rate set by the single read port of the slot memory.
// One item is in work at a time; the next transfer is taken while a result
// still waits in the output register under out_stall_i.
`default_nettype none
module slot_pool_with_bucket_lists #(
  parameter int unsigned NUM_SLOTS = spbl_pkg::NumSlotsDef,
  parameter int unsigned GRID_SIDE = spbl_pkg::GridSideDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [spbl_pkg::ActW-1:0]  action_i,
  input  wire logic [spbl_pkg::SlotW-1:0] slot_i,
  input  wire logic [spbl_pkg::TileW-1:0] tile_x_i,
  input  wire logic [spbl_pkg::TileW-1:0] tile_y_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [spbl_pkg::SlotW-1:0] slot_out_o,
  output logic      [spbl_pkg::StatW-1:0] status_o
);

  // Commands down to the datapath, flags back up
  spbl_pkg::dp_cmd_t    cmd;
  spbl_pkg::dp_status_t sts;

  // Sequencer: clear pass, action dispatch, scans, list walks, result hold
  spbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Slot memory {used, on_tile, next}, tile head memory, pointers, results
  spbl_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .action_i   (action_i),
    .slot_i     (slot_i),
    .tile_x_i   (tile_x_i),
    .tile_y_i   (tile_y_i),
    .slot_out_o (slot_out_o),
    .status_o   (status_o)
  );

endmodule
`default_nettype wire

FILE: rtl/spbl_chk.sv
// Port-level checker for slot_pool_with_bucket_lists, bound to the top level.
// Depends on spbl_pkg.
`default_nettype none
module spbl_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [spbl_pkg::SlotW-1:0] slot_out_o,
  input wire logic [spbl_pkg::StatW-1:0] status_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_out_o) && $stable(status_o))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != spbl_pkg::ST_OK |-> slot_out_o == '0)
    else $error("error result carries a slot");

  // An accepted item keeps in_stall_o high while it is in work
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transfer taken while busy");

endmodule

bind slot_pool_with_bucket_lists spbl_chk u_spbl_chk (.*);
`default_nettype wire
